FILE: rtl/lcdns_pkg.sv
// shared types, codes and the init nibble table for the lcd nibble sequencer
package lcdns_pkg;

  // action codes of a request
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_CMD   = 3'd1;
  localparam logic [2:0] ACT_DATA  = 3'd2;
  localparam logic [2:0] ACT_GOTO  = 3'd3;
  localparam logic [2:0] ACT_GLYPH = 3'd4;

  // controller constants
  localparam logic [7:0] LINE0_ADDR   = 8'h80;
  localparam logic [7:0] LINE1_ADDR   = 8'hC0;
  localparam logic [7:0] CGRAM_ADDR   = 8'h40;
  localparam logic [3:0] GLYPH_MAX    = 4'd8;
  localparam logic [4:0] WAIT_CMD_MS  = 5'd3;

  // last sequence index of each job kind
  localparam logic [4:0] INIT_LAST_IDX  = 5'd9;
  localparam logic [4:0] BYTE_LAST_IDX  = 5'd1;
  localparam logic [4:0] GLYPH_LAST_IDX = 5'd17;
  localparam logic [4:0] GLYPH_ROW0_IDX = 5'd2;

  // default depth of the job queue
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic [5:0]  column;
    logic        row;
    logic [3:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } in_item_t;

  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic [3:0] wait_before_ms;
    logic [4:0] wait_after_ms;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_BYTE,
    JOB_GLYPH
  } job_kind_t;

  // one classified request as it sits in the queue
  typedef struct packed {
    job_kind_t   kind;
    logic        rs;
    logic        wait_cmd;
    logic [7:0]  byte_val;
    logic [63:0] rows;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // one row of the power-up sequence
  typedef struct packed {
    logic [3:0] nibble;
    logic [3:0] before_ms;
    logic [4:0] after_ms;
  } init_step_t;

  // power-up sequence: 3,3,3,2 then 0x28, 0x0C, 0x01
  function automatic init_step_t init_step(input logic [3:0] idx);
    init_step_t s;
    case (idx)
      4'd0:    s = '{nibble: 4'h3, before_ms: 4'd15, after_ms: 5'd0};
      4'd1:    s = '{nibble: 4'h3, before_ms: 4'd5,  after_ms: 5'd0};
      4'd2:    s = '{nibble: 4'h3, before_ms: 4'd1,  after_ms: 5'd0};
      4'd3:    s = '{nibble: 4'h2, before_ms: 4'd1,  after_ms: 5'd0};
      4'd4:    s = '{nibble: 4'h2, before_ms: 4'd1,  after_ms: 5'd0};
      4'd5:    s = '{nibble: 4'h8, before_ms: 4'd0,  after_ms: 5'd0};
      4'd6:    s = '{nibble: 4'h0, before_ms: 4'd0,  after_ms: 5'd0};
      4'd7:    s = '{nibble: 4'hC, before_ms: 4'd0,  after_ms: 5'd0};
      4'd8:    s = '{nibble: 4'h0, before_ms: 4'd0,  after_ms: 5'd0};
      4'd9:    s = '{nibble: 4'h1, before_ms: 4'd0,  after_ms: 5'd30};
      default: s = '{nibble: 4'h0, before_ms: 4'd0,  after_ms: 5'd0};
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/lcdns_front.sv
// front end: classifies a request into a queue job or drops it
module lcdns_front (
  input  lcdns_pkg::in_item_t in_item,
  input  logic                in_take,
  output logic                job_push,
  output lcdns_pkg::job_t     job
);
  import lcdns_pkg::*;

  logic [7:0] goto_byte;
  logic [7:0] cgram_byte;

  // cursor address wraps to 8 bits
  assign goto_byte  = (in_item.row ? LINE1_ADDR : LINE0_ADDR) + {2'b00, in_item.column};
  // slot 8 wraps to 0 by the 3-bit mask
  assign cgram_byte = CGRAM_ADDR | {2'b00, in_item.glyph_slot[2:0], 3'b000};

  // classify the request
  always_comb begin
    job_push     = 1'b0;
    job.kind     = JOB_BYTE;
    job.rs       = 1'b0;
    job.wait_cmd = 1'b0;
    job.byte_val = in_item.byte_value;
    job.rows     = in_item.glyph_rows;
    case (in_item.action)
      ACT_INIT: begin
        job_push = in_take;
        job.kind = JOB_INIT;
      end
      ACT_CMD: begin
        job_push     = in_take;
        job.wait_cmd = 1'b1;
      end
      ACT_DATA: begin
        job_push = in_take;
        job.rs   = 1'b1;
      end
      ACT_GOTO: begin
        job_push     = in_take;
        job.byte_val = goto_byte;
      end
      ACT_GLYPH: begin
        job_push     = in_take && (in_item.glyph_slot <= GLYPH_MAX);
        job.kind     = JOB_GLYPH;
        job.byte_val = cgram_byte;
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/lcdns_queue.sv
// short job queue between front and back
module lcdns_queue #(
  parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcdns_pkg::job_t push_job,
  input  logic            pop,
  output logic            q_valid,
  output lcdns_pkg::job_t q_job,
  output logic            full
);
  import lcdns_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  job_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_job   = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  // a push on a full queue would lose a job
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  // pointers stay in step with the count
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with mismatched pointers");

endmodule

FILE: rtl/lcdns_back.sv
// back end: walks one job nibble by nibble onto the result port
module lcdns_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lcdns_pkg::job_t      q_job,
  output logic                 pop,
  output logic                 out_valid,
  output lcdns_pkg::out_item_t out_item
);
  import lcdns_pkg::*;

  back_state_t state_r, state_nxt;
  job_kind_t   kind_r, kind_nxt;
  logic        rs_r, rs_nxt;
  logic        wait_r, wait_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [63:0] rows_r, rows_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic [4:0]  last_idx;
  logic        is_last;
  logic        in_rows;
  logic        hi_half;
  logic [7:0]  cur_byte;
  init_step_t  istep;
  out_item_t   item;

  // position within the current job
  always_comb begin
    case (kind_r)
      JOB_INIT:  last_idx = INIT_LAST_IDX;
      JOB_BYTE:  last_idx = BYTE_LAST_IDX;
      JOB_GLYPH: last_idx = GLYPH_LAST_IDX;
      default:   last_idx = BYTE_LAST_IDX;
    endcase
  end

  assign is_last  = (idx_r == last_idx);
  assign in_rows  = (kind_r == JOB_GLYPH) && (idx_r >= GLYPH_ROW0_IDX);
  assign hi_half  = !idx_r[0];
  assign cur_byte = in_rows ? rows_r[7:0] : byte_r;
  assign istep    = init_step(idx_r[3:0]);

  // nibble for this cycle
  always_comb begin
    item.last = is_last;
    if (kind_r == JOB_INIT) begin
      item.register_select = 1'b0;
      item.nibble          = istep.nibble;
      item.wait_before_ms  = istep.before_ms;
      item.wait_after_ms   = istep.after_ms;
    end else begin
      item.register_select = (kind_r == JOB_GLYPH) ? in_rows : rs_r;
      item.nibble          = hi_half ? cur_byte[7:4] : cur_byte[3:0];
      item.wait_before_ms  = '0;
      item.wait_after_ms   = (kind_r == JOB_BYTE && wait_r && !hi_half) ? WAIT_CMD_MS : '0;
    end
  end

  // take the next job on the cycle the current one ends
  assign pop = q_valid && ((state_r == BK_IDLE) || is_last);

  // next state and job registers
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    rs_nxt    = rs_r;
    wait_nxt  = wait_r;
    byte_nxt  = byte_r;
    rows_nxt  = rows_r;
    idx_nxt   = idx_r;
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (is_last && !pop) begin
          state_nxt = BK_IDLE;
        end
        idx_nxt = idx_r + 1'b1;
        // next row byte after its low nibble
        if (in_rows && idx_r[0]) begin
          rows_nxt = {8'h00, rows_r[63:8]};
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    if (pop) begin
      kind_nxt = q_job.kind;
      rs_nxt   = q_job.rs;
      wait_nxt = q_job.wait_cmd;
      byte_nxt = q_job.byte_val;
      rows_nxt = q_job.rows;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == BK_RUN);
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    rs_r       <= rs_nxt;
    wait_r     <= wait_nxt;
    byte_r     <= byte_nxt;
    rows_r     <= rows_nxt;
    idx_r      <= idx_nxt;
    out_item_r <= item;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // the index never runs past the end of its job
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN) |-> (idx_r <= last_idx))
    else $error("sequence index past job end");

  // every running cycle yields one beat in the next cycle
  a_run_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN) |=> out_valid)
    else $error("running cycle without a beat");

  // a job that ends with nothing queued leaves the back end idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN) && is_last && !q_valid |=> (state_r == BK_IDLE))
    else $error("back end kept running after last nibble");

  // a new job always starts at its first nibble
  a_pop_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == '0) && (state_r == BK_RUN))
    else $error("job did not restart at index zero");

endmodule

FILE: rtl/char_lcd_nibble_sequencer_unit.sv
// top level of the character lcd 4-bit nibble sequencer
//
//  channel  ports                      direction  beat taken when
//  in       start, busy, in_item       in         start && !busy
//  out      out_valid, out_item        out        out_valid (one cycle, no stall)
//
// a request is classified by the front end and queued; the back end then
// sends one nibble per cycle: 10 for init, 2 for a byte or goto, 18 for a glyph.
// the back end picks up the next queued job in the cycle its last nibble goes, so
// nibbles flow without gaps; the result port sets the pace at one nibble a cycle.
// busy is high only while the job queue is full; dropped requests are not queued.
// reset empties the queue and idles the back end; on an idle block the first
// nibble passes the queue, the back end's job registers and its output register.
module char_lcd_nibble_sequencer_unit #(
  parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lcdns_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output lcdns_pkg::out_item_t out_item
);
  import lcdns_pkg::*;

  logic in_take;
  logic job_push;
  job_t job;
  logic q_valid;
  job_t q_job;
  logic q_full;
  logic pop;

  assign busy    = q_full;
  assign in_take = start && !q_full;

  // classify incoming requests
  lcdns_front u_front (
    .in_item  (in_item),
    .in_take  (in_take),
    .job_push (job_push),
    .job      (job)
  );

  // job queue
  lcdns_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .full     (q_full)
  );

  // nibble sequencer
  lcdns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: sim/char_lcd_nibble_sequencer_checker.sv
// checker: predicts nibble transfers per request and compares them with the result port
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  lcdns_pkg::in_item_t  in_item,
  input  logic                 out_valid,
  input  lcdns_pkg::out_item_t out_item,
  output int                   fail_count,
  output int                   outstanding
);
  import lcdns_pkg::*;

  // power-up wake sequence and the commands that follow it
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] FOUR_BIT_MODE = 4'h2;
  localparam logic [7:0] FUNC_SET_CMD  = 8'h28;
  localparam logic [7:0] DISPLAY_ON    = 8'h0C;
  localparam logic [7:0] CLEAR_CMD     = 8'h01;
  localparam logic [4:0] CLEAR_WAIT_MS = 5'd30;
  localparam int         REPORT_MAX    = 10;

  // nibbles still owed by the block, oldest first
  out_item_t due_nibbles[$];
  int        mismatches = 0;
  int        reported   = 0;
  int        due_count  = 0;

  assign fail_count  = mismatches;
  assign outstanding = due_count;

  function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                      input logic [3:0] wait_pre,
                                      input logic [4:0] wait_post);
    out_item_t n;
    n.register_select = rs;
    n.nibble          = nib;
    n.wait_before_ms  = wait_pre;
    n.wait_after_ms   = wait_post;
    n.last            = 1'b0;
    due_nibbles.push_back(n);
  endfunction

  // a byte goes high nibble first, same rs on both halves
  function automatic void push_byte(input logic rs, input logic [7:0] value,
                                    input logic [3:0] wait_pre,
                                    input logic [4:0] wait_post);
    push_nibble(rs, value[7:4], wait_pre, 5'd0);
    push_nibble(rs, value[3:0], 4'd0, wait_post);
  endfunction

  // expand one request into the nibble transfers it should cause
  function automatic void expand_request(input in_item_t req);
    int         base;
    int         i;
    logic [7:0] addr;
    logic [2:0] slot;
    base = due_nibbles.size();
    case (req.action)
      ACT_INIT: begin
        push_nibble(1'b0, WAKE_NIBBLE, 4'd15, 5'd0);
        push_nibble(1'b0, WAKE_NIBBLE, 4'd5, 5'd0);
        push_nibble(1'b0, WAKE_NIBBLE, 4'd1, 5'd0);
        push_nibble(1'b0, FOUR_BIT_MODE, 4'd1, 5'd0);
        push_byte(1'b0, FUNC_SET_CMD, 4'd1, 5'd0);
        push_byte(1'b0, DISPLAY_ON, 4'd0, 5'd0);
        push_byte(1'b0, CLEAR_CMD, 4'd0, CLEAR_WAIT_MS);
      end
      ACT_CMD: push_byte(1'b0, req.byte_value, 4'd0, WAIT_CMD_MS);
      ACT_DATA: push_byte(1'b1, req.byte_value, 4'd0, 5'd0);
      ACT_GOTO: begin
        // sum wraps to 8 bits
        addr = (req.row ? LINE1_ADDR : LINE0_ADDR) + {2'b00, req.column};
        push_byte(1'b0, addr, 4'd0, 5'd0);
      end
      ACT_GLYPH: begin
        // slots above the max are dropped, the max itself wraps to slot 0
        if (req.glyph_slot <= GLYPH_MAX) begin
          slot = req.glyph_slot[2:0];
          push_byte(1'b0, CGRAM_ADDR | {2'b00, slot, 3'b000}, 4'd0, 5'd0);
          for (i = 0; i < 8; i++) begin
            push_byte(1'b1, req.glyph_rows[8*i +: 8], 4'd0, 5'd0);
          end
        end
      end
      default: ;
    endcase
    if (due_nibbles.size() > base) begin
      due_nibbles[due_nibbles.size() - 1].last = 1'b1;
    end
  endfunction

  // watch both channels on every edge
  always @(posedge clk) begin
    out_item_t exp_n;
    logic      bad;
    if (rst_n) begin
      if (start && !busy) begin
        expand_request(in_item);
      end
      if (out_valid) begin
        if (due_nibbles.size() == 0) begin
          mismatches <= mismatches + 1;
          if (reported < REPORT_MAX) begin
            $display("%0t: unexpected nibble beat rs=%0b nib=%h pre=%0d post=%0d last=%0b",
                     $time, out_item.register_select, out_item.nibble,
                     out_item.wait_before_ms, out_item.wait_after_ms, out_item.last);
          end
          reported <= reported + 1;
        end else begin
          exp_n = due_nibbles.pop_front();
          bad = (out_item.register_select !== exp_n.register_select) ||
                (out_item.nibble !== exp_n.nibble) ||
                (out_item.wait_before_ms !== exp_n.wait_before_ms) ||
                (out_item.wait_after_ms !== exp_n.wait_after_ms) ||
                (out_item.last !== exp_n.last);
          if (bad) begin
            mismatches <= mismatches + 1;
            if (reported < REPORT_MAX) begin
              $display("%0t: nibble mismatch exp rs=%0b nib=%h pre=%0d post=%0d last=%0b",
                       $time, exp_n.register_select, exp_n.nibble,
                       exp_n.wait_before_ms, exp_n.wait_after_ms, exp_n.last);
              $display("%0t:                 got rs=%0b nib=%h pre=%0d post=%0d last=%0b",
                       $time, out_item.register_select, out_item.nibble,
                       out_item.wait_before_ms, out_item.wait_after_ms, out_item.last);
            end
            reported <= reported + 1;
          end
        end
      end
      due_count <= due_nibbles.size();
    end
  end

endmodule

FILE: sim/tb_char_lcd_nibble_sequencer_unit.sv
// testbench top: request stimulus, clock, reset and verdict for the lcd nibble sequencer
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer_unit;
  import lcdns_pkg::*;

  // action codes the block ignores
  localparam logic [2:0] ACT_UNUSED_A = 3'd5;
  localparam logic [2:0] ACT_UNUSED_B = 3'd6;
  localparam logic [2:0] ACT_UNUSED_C = 3'd7;
  localparam int         USEFUL_GOAL  = 75;
  localparam int         DRAIN_CYCLES = 64;
  localparam int         CYCLE_LIMIT  = 200000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        outstanding;
  int        cycle_count = 0;

  char_lcd_nibble_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  char_lcd_nibble_sequencer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_char_lcd_nibble_sequencer_unit failed");
      $finish;
    end
  end

  function automatic in_item_t build_request(input logic [2:0] act, input logic [7:0] value,
                                             input logic [5:0] col, input logic line,
                                             input logic [3:0] slot,
                                             input logic [63:0] rows);
    in_item_t r;
    r.action     = act;
    r.byte_value = value;
    r.column     = col;
    r.row        = line;
    r.glyph_slot = slot;
    r.glyph_rows = rows;
    return r;
  endfunction

  // random request; mostly well-formed, some dropped glyphs and ignored actions
  function automatic in_item_t random_request();
    int         pick;
    logic [2:0] act;
    logic [3:0] slot;
    pick = $urandom_range(0, 99);
    slot = 4'($urandom_range(0, GLYPH_MAX));
    if (pick < 6)       act = ACT_INIT;
    else if (pick < 26) act = ACT_CMD;
    else if (pick < 48) act = ACT_DATA;
    else if (pick < 68) act = ACT_GOTO;
    else if (pick < 90) act = ACT_GLYPH;
    else if (pick < 95) begin
      act  = ACT_GLYPH;
      slot = 4'($urandom_range(GLYPH_MAX + 1, 15));
    end else begin
      case ($urandom_range(0, 2))
        0:       act = ACT_UNUSED_A;
        1:       act = ACT_UNUSED_B;
        default: act = ACT_UNUSED_C;
      endcase
    end
    return build_request(act, 8'($urandom), 6'($urandom), 1'($urandom), slot,
                         {$urandom, $urandom});
  endfunction

  // drive one beat and hold it until the block takes it
  task automatic send_request(input in_item_t req);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender holds off until every owed nibble has come out
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int       useful;
    int       burst;
    int       gap;
    bit       paused;
    in_item_t req;
    useful = 0;
    paused = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every action, slot wrap and drop, ignored actions
    send_request(build_request(ACT_INIT, 8'h00, 6'd0, 1'b0, 4'd0, 64'd0));
    send_request(build_request(ACT_CMD, 8'h00, 6'd0, 1'b0, 4'd0, 64'd0));
    send_request(build_request(ACT_CMD, 8'hFF, 6'h3F, 1'b1, 4'hF, '1));
    send_request(build_request(ACT_DATA, 8'h00, 6'd0, 1'b0, 4'd0, 64'd0));
    send_request(build_request(ACT_DATA, 8'hFF, 6'h3F, 1'b1, 4'hF, '1));
    send_request(build_request(ACT_GOTO, 8'h00, 6'd0, 1'b0, 4'd0, 64'd0));
    send_request(build_request(ACT_GOTO, 8'hFF, 6'd39, 1'b1, 4'd0, 64'd0));
    send_request(build_request(ACT_GOTO, 8'h00, 6'h3F, 1'b0, 4'd0, 64'd0));
    send_request(build_request(ACT_GOTO, 8'h00, 6'h3F, 1'b1, 4'd0, 64'd0));
    send_request(build_request(ACT_GLYPH, 8'h00, 6'd0, 1'b0, 4'd0, '1));
    send_request(build_request(ACT_GLYPH, 8'h00, 6'd0, 1'b0, 4'd7,
                               64'h0123_4567_89AB_CDEF));
    send_request(build_request(ACT_GLYPH, 8'h00, 6'd0, 1'b0, GLYPH_MAX,
                               64'hFEDC_BA98_7654_3210));
    send_request(build_request(ACT_GLYPH, 8'hFF, 6'd0, 1'b0, GLYPH_MAX + 4'd1, '1));
    send_request(build_request(ACT_GLYPH, 8'hFF, 6'd0, 1'b0, 4'hF, '1));
    send_request(build_request(ACT_UNUSED_A, 8'hFF, 6'h3F, 1'b1, 4'd0, '1));
    send_request(build_request(ACT_UNUSED_B, 8'h00, 6'd0, 1'b0, 4'd0, 64'd0));
    send_request(build_request(ACT_UNUSED_C, 8'h5A, 6'd1, 1'b1, 4'd3, 64'd0));
    send_request(build_request(ACT_DATA, 8'hA5, 6'd0, 1'b0, 4'd0, 64'd0));
    hold_until_drained();

    // random part in bursts with random gaps
    while (useful < USEFUL_GOAL) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      repeat (burst) begin
        req = random_request();
        if (req.action == ACT_INIT || req.action == ACT_CMD || req.action == ACT_DATA ||
            req.action == ACT_GOTO ||
            (req.action == ACT_GLYPH && req.glyph_slot <= GLYPH_MAX)) begin
          useful++;
        end
        send_request(req);
      end
      if (!paused && useful >= USEFUL_GOAL / 2) begin
        paused = 1'b1;
        hold_until_drained();
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // drain and give the verdict
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_char_lcd_nibble_sequencer_unit passed");
    end else begin
      $display("tb_char_lcd_nibble_sequencer_unit failed");
    end
    $finish;
  end

endmodule
